// ----- rtl/vtcs_pkg.sv -----
// shared types and constants of the voxel terrain column span block
// no dependencies; used by every module under rtl
`default_nettype none

package vtcs_pkg;

  // field widths of the beats
  localparam int COL_W  = 10;
  localparam int Z_W    = 10;
  localparam int HGT_W  = 8;
  localparam int CH_W   = 8;
  localparam int SPAN_W = 9;
  localparam int IN_W   = 56;
  localparam int OUT_W  = 56;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 11;
  localparam int EYE_W      = 10;
  localparam int HOR_W      = 11;
  localparam int FAR_W      = 11;

  localparam logic [CFG_ADDR_W-1:0] CFG_EYE_HEIGHT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HORIZON_ROW  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_FAR_DISTANCE = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_FOG_RED      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_FOG_GREEN    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_FOG_BLUE     = 3'd5;

  // arithmetic widths
  localparam int PNUM_W = 23;  // signed projection numerator
  localparam int ZSQ_W  = 20;  // z squared
  localparam int DIVR_W = 22;  // divisor, far distance squared at most
  localparam int REM_W  = 23;  // partial remainder
  localparam int QUO_W  = 21;  // quotient bits of the projection divide
  localparam int PROD_W = 30;  // blend partial products
  localparam int DNUM_W = 31;  // signed blend numerator

  localparam logic signed [PNUM_W-1:0] HEIGHT_SCALE = 23'sd400;

  // divider step counts
  localparam int CNT_W      = 5;
  localparam int PROJ_STEPS = QUO_W;
  localparam int CHAN_STEPS = CH_W;

  // colour channel select
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       prep;
    logic       pdiv_start;
    logic       div_step;
    logic       row_take;
    logic       chan_mul;
    logic       chan_sum;
    logic       cdiv_start;
    logic       chan_store;
    logic       emit;
    logic [1:0] chan_sel;
  } vtcs_cmd_t;

  typedef struct packed {
    logic visible;
    logic out_free;
  } vtcs_stat_t;

endpackage

`default_nettype wire

// ----- rtl/vtcs_div.sv -----
// shared restoring divider, one quotient bit per cycle while step is high
// depends on vtcs_pkg for widths
`default_nettype none

module vtcs_div (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [vtcs_pkg::REM_W-1:0]    init_rem,
  input  logic [vtcs_pkg::QUO_W-1:0]    init_shift,
  input  logic [vtcs_pkg::DIVR_W-1:0]   divisor,
  output logic [vtcs_pkg::QUO_W-1:0]    quotient
);

  logic [vtcs_pkg::REM_W-1:0]  rem_r;
  logic [vtcs_pkg::REM_W-1:0]  rem_nxt;
  logic [vtcs_pkg::REM_W-1:0]  trial;
  logic [vtcs_pkg::QUO_W-1:0]  sh_r;
  logic [vtcs_pkg::QUO_W-1:0]  quo_r;
  logic [vtcs_pkg::DIVR_W-1:0] dvs_r;
  logic                        fits;

  // bring down the next dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r[vtcs_pkg::REM_W-2:0], sh_r[vtcs_pkg::QUO_W-1]};
    fits    = trial >= vtcs_pkg::REM_W'(dvs_r);
    rem_nxt = fits ? trial - vtcs_pkg::REM_W'(dvs_r) : trial;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= init_rem;
      sh_r  <= init_shift;
      dvs_r <= divisor;
      quo_r <= '0;
    end else if (step) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[vtcs_pkg::QUO_W-2:0], 1'b0};
      quo_r <= {quo_r[vtcs_pkg::QUO_W-2:0], fits};
    end
  end

  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/vtcs_ctrl.sv -----
// sequencer of the span block: steps the datapath through projection and fog
// depends on vtcs_pkg for command and status structs
`default_nettype none

module vtcs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  vtcs_pkg::vtcs_stat_t stat,
  output vtcs_pkg::vtcs_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_PSTART = 4'd2;
  localparam logic [3:0] S_PDIV   = 4'd3;
  localparam logic [3:0] S_ROW    = 4'd4;
  localparam logic [3:0] S_TEST   = 4'd5;
  localparam logic [3:0] S_CMUL   = 4'd6;
  localparam logic [3:0] S_CSUM   = 4'd7;
  localparam logic [3:0] S_CSTART = 4'd8;
  localparam logic [3:0] S_CDIV   = 4'd9;
  localparam logic [3:0] S_CSTORE = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;

  logic [3:0]                 state_r, state_nxt;
  logic [vtcs_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]                 ch_r, ch_nxt;

  always_comb begin
    cmd          = '0;
    cmd.chan_sel = ch_r;
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ch_nxt       = ch_r;
    in_tready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_PSTART;
      end
      S_PSTART: begin
        cmd.pdiv_start = 1'b1;
        cnt_nxt        = vtcs_pkg::CNT_W'(vtcs_pkg::PROJ_STEPS - 1);
        state_nxt      = S_PDIV;
      end
      S_PDIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_ROW;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_ROW: begin
        cmd.row_take = 1'b1;
        state_nxt    = S_TEST;
      end
      S_TEST: begin
        if (stat.visible) begin
          ch_nxt    = vtcs_pkg::CH_RED;
          state_nxt = S_CMUL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CMUL: begin
        cmd.chan_mul = 1'b1;
        state_nxt    = S_CSUM;
      end
      S_CSUM: begin
        cmd.chan_sum = 1'b1;
        state_nxt    = S_CSTART;
      end
      S_CSTART: begin
        cmd.cdiv_start = 1'b1;
        cnt_nxt        = vtcs_pkg::CNT_W'(vtcs_pkg::CHAN_STEPS - 1);
        state_nxt      = S_CDIV;
      end
      S_CDIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_CSTORE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_CSTORE: begin
        cmd.chan_store = 1'b1;
        if (ch_r == vtcs_pkg::CH_BLUE) begin
          state_nxt = S_EMIT;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_CMUL;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ch_r    <= vtcs_pkg::CH_RED;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ch_r    <= ch_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/vtcs_dp.sv -----
// datapath of the span block: config registers, projection, occlusion row,
// fog blend and output register; depends on vtcs_pkg and vtcs_div
`default_nettype none

module vtcs_dp #(
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vtcs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [vtcs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [vtcs_pkg::IN_W-1:0]           in_tdata,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [vtcs_pkg::OUT_W-1:0]          out_tdata,
  input  vtcs_pkg::vtcs_cmd_t                 cmd,
  output vtcs_pkg::vtcs_stat_t                stat
);

  localparam int ROW_W = $clog2(SCREEN_HEIGHT);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [vtcs_pkg::QUO_W-1:0] QUO_ROW_MAX =
    vtcs_pkg::QUO_W'(SCREEN_HEIGHT - 1);

  // configuration
  logic [vtcs_pkg::EYE_W-1:0]        eye_r;
  logic signed [vtcs_pkg::HOR_W-1:0] hor_r;
  logic [vtcs_pkg::FAR_W-1:0]        far_r;
  logic [vtcs_pkg::CH_W-1:0]         fog_red_r, fog_green_r, fog_blue_r;

  // sample
  logic [vtcs_pkg::COL_W-1:0] col_r;
  logic [vtcs_pkg::Z_W-1:0]   z_r;
  logic [vtcs_pkg::HGT_W-1:0] h_r;
  logic [vtcs_pkg::CH_W-1:0]  cr_r, cg_r, cb_r;
  logic [vtcs_pkg::Z_W-1:0]   z_in;

  // arithmetic
  logic signed [vtcs_pkg::PNUM_W-1:0] pnum_r, pnum_nxt;
  logic signed [vtcs_pkg::PNUM_W-1:0] eye_s, h_s, hor_s, z_s;
  logic [vtcs_pkg::ZSQ_W-1:0]         zsq_r;
  logic [vtcs_pkg::DIVR_W-1:0]        fsq_r;
  logic [vtcs_pkg::FAR_W-1:0]         far_eff;
  logic [ROW_W-1:0]                   row_r, row_nxt, occ_r;
  logic [vtcs_pkg::CH_W-1:0]          c_sel, fog_sel;
  logic signed [vtcs_pkg::PROD_W-1:0] diff_x, zsq_x, prodf_r;
  logic [vtcs_pkg::PROD_W-1:0]        prodc_r;
  logic signed [vtcs_pkg::DNUM_W-1:0] dnum_r, dnum_nxt;
  logic                               zero_r, sat_r;
  logic [vtcs_pkg::CH_W-1:0]          chan_res;
  logic [vtcs_pkg::CH_W-1:0]          ch_red_r, ch_green_r, ch_blue_r;

  // divider hookup
  logic                         div_load;
  logic [vtcs_pkg::REM_W-1:0]   div_rem;
  logic [vtcs_pkg::QUO_W-1:0]   div_shift;
  logic [vtcs_pkg::DIVR_W-1:0]  div_dvs;
  logic [vtcs_pkg::QUO_W-1:0]   quo;

  // output register
  logic                         out_valid_r;
  logic [vtcs_pkg::COL_W-1:0]   out_col_r;
  logic [ROW_W-1:0]             out_top_r, out_bot_r;
  logic [vtcs_pkg::CH_W-1:0]    out_red_r, out_green_r, out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_r       <= 10'd200;
      hor_r       <= 11'sd120;
      far_r       <= 11'd300;
      fog_red_r   <= '0;
      fog_green_r <= '0;
      fog_blue_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        vtcs_pkg::CFG_EYE_HEIGHT:   eye_r       <= cfg_wdata[vtcs_pkg::EYE_W-1:0];
        vtcs_pkg::CFG_HORIZON_ROW:  hor_r       <= signed'(cfg_wdata[vtcs_pkg::HOR_W-1:0]);
        vtcs_pkg::CFG_FAR_DISTANCE: far_r       <= cfg_wdata[vtcs_pkg::FAR_W-1:0];
        vtcs_pkg::CFG_FOG_RED:      fog_red_r   <= cfg_wdata[vtcs_pkg::CH_W-1:0];
        vtcs_pkg::CFG_FOG_GREEN:    fog_green_r <= cfg_wdata[vtcs_pkg::CH_W-1:0];
        vtcs_pkg::CFG_FOG_BLUE:     fog_blue_r  <= cfg_wdata[vtcs_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  assign z_in = in_tdata[19:10];

  always_comb begin
    // projection numerator (eye - h) * 400 + horizon * z
    eye_s    = signed'(vtcs_pkg::PNUM_W'(eye_r));
    h_s      = signed'(vtcs_pkg::PNUM_W'(h_r));
    hor_s    = vtcs_pkg::PNUM_W'(hor_r);
    z_s      = signed'(vtcs_pkg::PNUM_W'(z_r));
    pnum_nxt = (eye_s - h_s) * vtcs_pkg::HEIGHT_SCALE + hor_s * z_s;
    far_eff  = (far_r == '0) ? vtcs_pkg::FAR_W'(1) : far_r;

    // row clamp: non-positive numerator lands on row 0
    if (pnum_r[vtcs_pkg::PNUM_W-1] || pnum_r == '0) begin
      row_nxt = '0;
    end else if (quo > QUO_ROW_MAX) begin
      row_nxt = ROW_MAX;
    end else begin
      row_nxt = quo[ROW_W-1:0];
    end

    unique case (cmd.chan_sel)
      vtcs_pkg::CH_RED: begin
        c_sel   = cr_r;
        fog_sel = fog_red_r;
      end
      vtcs_pkg::CH_GREEN: begin
        c_sel   = cg_r;
        fog_sel = fog_green_r;
      end
      default: begin
        c_sel   = cb_r;
        fog_sel = fog_blue_r;
      end
    endcase
    diff_x   = signed'(vtcs_pkg::PROD_W'(fog_sel)) - signed'(vtcs_pkg::PROD_W'(c_sel));
    zsq_x    = signed'(vtcs_pkg::PROD_W'(zsq_r));
    dnum_nxt = signed'(vtcs_pkg::DNUM_W'(prodc_r)) + vtcs_pkg::DNUM_W'(prodf_r);

    // saturated or non-positive channels bypass the quotient
    if (zero_r) begin
      chan_res = '0;
    end else if (sat_r) begin
      chan_res = '1;
    end else begin
      chan_res = quo[vtcs_pkg::CH_W-1:0];
    end

    div_load = cmd.pdiv_start | cmd.cdiv_start;
    if (cmd.cdiv_start) begin
      div_rem   = vtcs_pkg::REM_W'(dnum_r[vtcs_pkg::PROD_W-1:vtcs_pkg::CHAN_STEPS]);
      div_shift = {dnum_r[vtcs_pkg::CHAN_STEPS-1:0],
                   {(vtcs_pkg::QUO_W - vtcs_pkg::CHAN_STEPS){1'b0}}};
      div_dvs   = fsq_r;
    end else begin
      div_rem   = '0;
      div_shift = pnum_r[vtcs_pkg::QUO_W-1:0];
      div_dvs   = vtcs_pkg::DIVR_W'(z_r);
    end
  end

  vtcs_div u_div (
    .clk        (clk),
    .load       (div_load),
    .step       (cmd.div_step),
    .init_rem   (div_rem),
    .init_shift (div_shift),
    .divisor    (div_dvs),
    .quotient   (quo)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      col_r <= in_tdata[9:0];
      z_r   <= (z_in == '0) ? vtcs_pkg::Z_W'(1) : z_in;
      h_r   <= in_tdata[27:20];
      cr_r  <= in_tdata[35:28];
      cg_r  <= in_tdata[43:36];
      cb_r  <= in_tdata[51:44];
    end
    if (cmd.prep) begin
      pnum_r <= pnum_nxt;
      zsq_r  <= vtcs_pkg::ZSQ_W'(z_r) * vtcs_pkg::ZSQ_W'(z_r);
      fsq_r  <= vtcs_pkg::DIVR_W'(far_eff) * vtcs_pkg::DIVR_W'(far_eff);
    end
    if (cmd.row_take) begin
      row_r <= row_nxt;
    end
    if (cmd.chan_mul) begin
      prodc_r <= vtcs_pkg::PROD_W'(c_sel) * vtcs_pkg::PROD_W'(fsq_r);
      prodf_r <= diff_x * zsq_x;
    end
    if (cmd.chan_sum) begin
      dnum_r <= dnum_nxt;
    end
    if (cmd.cdiv_start) begin
      zero_r <= dnum_r[vtcs_pkg::DNUM_W-1] || dnum_r == '0;
      sat_r  <= dnum_r[vtcs_pkg::PROD_W-1:0] >= {fsq_r, {vtcs_pkg::CH_W{1'b0}}};
    end
    if (cmd.chan_store) begin
      unique case (cmd.chan_sel)
        vtcs_pkg::CH_RED:   ch_red_r   <= chan_res;
        vtcs_pkg::CH_GREEN: ch_green_r <= chan_res;
        default:            ch_blue_r  <= chan_res;
      endcase
    end
    if (cmd.emit) begin
      out_col_r   <= col_r;
      out_top_r   <= row_r;
      out_bot_r   <= occ_r;
      out_red_r   <= ch_red_r;
      out_green_r <= ch_green_r;
      out_blue_r  <= ch_blue_r;
    end
  end

  // occlusion row and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= ROW_MAX;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.prep && z_r == vtcs_pkg::Z_W'(1)) begin
        occ_r <= ROW_MAX;
      end else if (cmd.emit) begin
        occ_r <= row_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.visible  = row_r < occ_r;
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_blue_r, out_green_r, out_red_r,
                       vtcs_pkg::SPAN_W'(out_bot_r), vtcs_pkg::SPAN_W'(out_top_r),
                       out_col_r};

endmodule

`default_nettype wire

// ----- rtl/voxel_terrain_column_spans_top.sv -----
// top level of the voxel terrain column span block
// depends on vtcs_pkg, vtcs_ctrl, vtcs_dp (which holds vtcs_div)
//
// usage:
// - in_* carries one ray-march sample per beat; step depth 1 (or 0) opens a
//   new screen column and resets that column's occlusion row to the bottom
// - out_* carries one vertical span per visible sample: rows top (inclusive)
//   to bottom (exclusive) of one column, filled with the fogged colour
// - cfg_* writes camera and fog registers; write only while the block is idle
// - one sample is worked at a time; in_tready is high only between samples
// - a hidden sample runs prep, divide, row and test before in_tready returns
// - a visible sample adds three colour passes until its span sits in the
//   output register; the next sample is taken while that span still waits
// - the time goes to one shared restoring divider, one quotient bit per
//   cycle: 21 bits for the row projection, 8 bits for each colour channel
// - a stalled out_tready holds the span in the output register; a further
//   visible sample waits at its last step until that register frees up
// - synchronous reset clears the sequencer, empties the output register,
//   restores the register defaults and puts the occlusion row at the bottom
`default_nettype none

module voxel_terrain_column_spans_top #(
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample beats
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // column, step_depth, height_sample, color_red, color_green, color_blue
  input  logic [vtcs_pkg::IN_W-1:0]         in_tdata,
  // span beats
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // span_column, span_top, span_bottom, out_red, out_green, out_blue
  output logic [vtcs_pkg::OUT_W-1:0]        out_tdata,
  // register writes
  input  logic                              cfg_we,
  input  logic [vtcs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [vtcs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // commands down from the sequencer, status back up
  vtcs_pkg::vtcs_cmd_t  cmd;
  vtcs_pkg::vtcs_stat_t stat;

  vtcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vtcs_dp #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

  // the sequencer must leave idle once it has taken a sample
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("sample accepted but sequencer stayed ready");

  // a span needs the full divide, so it never shows up right after a beat in
  a_no_instant_span: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("span appeared one cycle after a sample beat");

  // a span always covers at least one row; checked while SCREEN_HEIGHT <= 512
  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && SCREEN_HEIGHT <= 512) |-> (out_tdata[18:10] < out_tdata[27:19]))
    else $error("span top not above span bottom");

endmodule

`default_nettype wire
